@@ rtl/bcm_pkg.sv @@
package bcm_pkg;

  localparam int CHANNEL_COUNT = 14;
  localparam int MAILBOX_BYTES = 128;

  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [7:0] FREE_LIMIT = 8'(MAILBOX_BYTES - 1);

  localparam logic [1:0] CMD_SETUP      = 2'd0;
  localparam logic [1:0] CMD_DISABLE    = 2'd1;
  localparam logic [1:0] CMD_REACTIVATE = 2'd2;
  localparam logic [1:0] CMD_RESET_ALL  = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_CHANNEL  = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY    = 2'd2;
  localparam logic [1:0] ST_NOT_OCCUPIED = 2'd3;

  localparam logic [2:0] MODE_TRANSMIT  = 3'd0;
  localparam logic [2:0] MODE_RECEIVE   = 3'd1;
  localparam logic [2:0] MODE_RR_NO_TX  = 3'd2;
  localparam logic [2:0] MODE_RR        = 3'd3;
  localparam logic [2:0] MODE_IMMEDIATE = 3'd4;
  localparam logic [2:0] MODE_DEFERRED  = 3'd5;
  localparam logic [2:0] MODE_DETECT    = 3'd6;

  // Length/status byte that idles a channel.
  localparam logic [7:0] DISABLE_LEN_STATUS = 8'h0F;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  channel;
    logic [11:0] identifier;
    logic [2:0]  mode;
    logic [4:0]  msg_length;
    logic        ack_flag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       write_regs;
    logic [6:0] mailbox_addr;
    logic [7:0] reg_ident_high;
    logic [7:0] reg_ident_command;
    logic [7:0] reg_message_pointer;
    logic [7:0] reg_length_status;
    logic [7:0] reg_mask_high;
    logic [7:0] reg_mask_low;
  } rsp_t;

  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // process the held request and load the result register
  } dp_cmd_t;

endpackage

@@ rtl/bus_channel_mailbox_setup.sv @@
// Channel table and mailbox allocator of a serial vehicle-bus controller.
//
// Request channel (in_valid_i / in_stall_o / in_req_i): one transaction
// carries a command (setup, disable, reactivate, reset all) with channel,
// identifier, mode, length and acknowledge flag.
// Response channel (out_valid_o / out_stall_i / out_rsp_o): exactly one
// transaction per request, in request order, with status, mailbox address
// and the channel register bytes to write.
//
// Sequencing: a request is first taken into the request register; it is
// processed when the result register is free, and its result is then
// offered from the result register. The channel table entry read,
// allocation and write-back run in the process step. A new request is not
// accepted until the held request has been processed.
// The result register lets the next request be accepted while a result
// still waits; while out_stall_i is high the result holds and the held
// request waits for the register to drain.
// Reset clears every channel entry and the free pointer; no clearing pass
// is needed, and requests are accepted from the first cycle after reset.
module bus_channel_mailbox_setup import bcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  // Command bundle from the sequencer to the datapath.
  dp_cmd_t dp_cmd;

  // Sequencer: request hold, process step and result-register handshake.
  bcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath: channel table, bump allocator and register-byte encoding.
  bcm_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .dp_cmd_i (dp_cmd),
    .req_i    (in_req_i),
    .rsp_o    (out_rsp_o)
  );

endmodule

@@ rtl/bcm_ctrl.sv @@
module bcm_ctrl import bcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t dp_cmd_o
);

  typedef enum logic [0:0] {S_IDLE, S_EXEC} state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    dp_cmd_o.load = in_valid_i && (state_q == S_IDLE);
    dp_cmd_o.exec = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (dp_cmd_o.load) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (dp_cmd_o.exec) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (dp_cmd_o.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.exec |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.exec |=> out_valid_q)
    else $error("processed request produced no result");
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted request not scheduled");
`endif

endmodule

@@ rtl/bcm_datapath.sv @@
module bcm_datapath import bcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t dp_cmd_i,
  input  req_t    req_i,
  output rsp_t    rsp_o
);

  req_t req_q;
  rsp_t rsp_q;
  rsp_t rsp_d;

  logic        chan_occ_q   [CHANNEL_COUNT];
  logic [11:0] chan_ident_q [CHANNEL_COUNT];
  logic [6:0]  chan_loc_q   [CHANNEL_COUNT];
  logic [4:0]  chan_rlen_q  [CHANNEL_COUNT];
  logic [7:0]  chan_ls_q    [CHANNEL_COUNT];
  logic [6:0]  next_free_q;
  logic [6:0]  next_free_d;

  logic [CH_IDX_W-1:0] idx;
  logic        chan_ok;
  logic        e_occ;
  logic [11:0] e_ident;
  logic [6:0]  e_loc;
  logic [4:0]  e_rlen;
  logic [7:0]  e_ls;
  logic [7:0]  free_sum;
  logic        rnw, rtr, rak, drak, chtx, chrx;
  logic [6:0]  addr;
  logic [7:0]  ls;
  logic        wr_setup, wr_slot, wr_disable, clear_all;

  assign idx     = req_q.channel[CH_IDX_W-1:0];
  assign chan_ok = ({1'b0, req_q.channel} < 5'(CHANNEL_COUNT));

  always_comb begin
    e_occ   = 1'b0;
    e_ident = '0;
    e_loc   = '0;
    e_rlen  = '0;
    e_ls    = '0;
    if (chan_ok) begin
      e_occ   = chan_occ_q[idx];
      e_ident = chan_ident_q[idx];
      e_loc   = chan_loc_q[idx];
      e_rlen  = chan_rlen_q[idx];
      e_ls    = chan_ls_q[idx];
    end
  end

  assign free_sum = {1'b0, next_free_q} + {3'b000, req_q.msg_length};

  // Mode decode for the command, pointer and length/status registers.
  always_comb begin
    rnw  = 1'b1;
    rtr  = 1'b0;
    rak  = 1'b0;
    drak = 1'b1;
    chtx = 1'b0;
    chrx = 1'b0;
    case (req_q.mode)
      MODE_TRANSMIT: begin
        rnw = 1'b0; rak = req_q.ack_flag; drak = 1'b0;
      end
      MODE_RECEIVE: begin
        rnw = 1'b0; rtr = 1'b1; drak = !req_q.ack_flag;
      end
      MODE_RR_NO_TX: begin
        rtr = 1'b1;
      end
      MODE_RR: begin
        rtr = 1'b1; rak = req_q.ack_flag;
      end
      MODE_IMMEDIATE: begin
        drak = 1'b0;
      end
      MODE_DEFERRED: begin
        drak = !req_q.ack_flag; chrx = 1'b1;
      end
      default: begin
        chtx = 1'b1;
      end
    endcase
  end

  assign ls = {5'(req_q.msg_length + 5'd1), 1'b0, chtx, chrx};

  always_comb begin
    rsp_d       = '0;
    next_free_d = next_free_q;
    addr        = e_loc;
    wr_setup    = 1'b0;
    wr_slot     = 1'b0;
    wr_disable  = 1'b0;
    clear_all   = 1'b0;
    case (req_q.cmd)
      CMD_SETUP: begin
        if (!chan_ok || req_q.mode > MODE_DETECT ||
            (e_occ && e_ident != req_q.identifier)) begin
          rsp_d.status = ST_BAD_CHANNEL;
        end else begin
          if (e_occ || (e_rlen != 5'd0 && req_q.msg_length <= e_rlen)) begin
            wr_setup = 1'b1;
          end else if (free_sum <= FREE_LIMIT) begin
            addr        = next_free_q;
            wr_setup    = 1'b1;
            wr_slot     = 1'b1;
            next_free_d = free_sum[6:0];
          end else begin
            rsp_d.status = ST_NO_MEMORY;
          end
          if (wr_setup) begin
            rsp_d.status              = ST_OK;
            rsp_d.write_regs          = 1'b1;
            rsp_d.mailbox_addr        = addr;
            rsp_d.reg_ident_high      = req_q.identifier[11:4];
            rsp_d.reg_ident_command   = {req_q.identifier[3:0], 1'b1, rak, rnw, rtr};
            rsp_d.reg_message_pointer = {drak, addr};
            rsp_d.reg_length_status   = ls;
            rsp_d.reg_mask_high       = req_q.identifier[11:4];
            rsp_d.reg_mask_low        = {4'h0, req_q.identifier[3:0]};
          end
        end
      end
      CMD_RESET_ALL: begin
        clear_all                = 1'b1;
        next_free_d              = '0;
        rsp_d.write_regs         = 1'b1;
        rsp_d.reg_length_status  = DISABLE_LEN_STATUS;
      end
      CMD_DISABLE: begin
        if (!chan_ok) begin
          rsp_d.status = ST_BAD_CHANNEL;
        end else begin
          wr_disable              = 1'b1;
          rsp_d.write_regs        = 1'b1;
          rsp_d.reg_length_status = DISABLE_LEN_STATUS;
        end
      end
      default: begin
        if (!chan_ok) begin
          rsp_d.status = ST_BAD_CHANNEL;
        end else if (e_occ) begin
          rsp_d.mailbox_addr      = e_loc;
          rsp_d.reg_length_status = e_ls;
        end else begin
          rsp_d.status = ST_NOT_OCCUPIED;
        end
      end
    endcase
  end

  // Payload registers: request hold and result register.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) req_q <= req_i;
    if (dp_cmd_i.exec) rsp_q <= rsp_d;
  end

  // Channel table and free pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_occ_q[i]   <= 1'b0;
        chan_ident_q[i] <= '0;
        chan_loc_q[i]   <= '0;
        chan_rlen_q[i]  <= '0;
        chan_ls_q[i]    <= '0;
      end
    end else if (dp_cmd_i.exec) begin
      next_free_q <= next_free_d;
      if (clear_all) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          chan_occ_q[i]   <= 1'b0;
          chan_ident_q[i] <= '0;
          chan_loc_q[i]   <= '0;
          chan_rlen_q[i]  <= '0;
          chan_ls_q[i]    <= '0;
        end
      end else begin
        if (wr_disable) chan_occ_q[idx] <= 1'b0;
        if (wr_setup) begin
          chan_occ_q[idx]   <= 1'b1;
          chan_ident_q[idx] <= req_q.identifier;
          chan_ls_q[idx]    <= ls;
        end
        if (wr_slot) begin
          chan_loc_q[idx]  <= addr;
          chan_rlen_q[idx] <= req_q.msg_length;
        end
      end
    end
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, next_free_q} <= FREE_LIMIT))
    else $error("free pointer beyond mailbox");
  a_alloc_only_on_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.exec && wr_slot) |-> (req_q.cmd == CMD_SETUP && rsp_d.status == ST_OK))
    else $error("slot allocated outside successful setup");
  a_free_moves_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.exec && !wr_slot && !clear_all) |=> $stable(next_free_q))
    else $error("free pointer moved without allocation");
`endif

endmodule
